@@ sv/tcc_pkg.sv @@
package tcc_pkg;

  // Screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int ADDR_W  = $clog2(CELLS);

  // Field widths
  localparam int CMD_W    = 3;
  localparam int CHAR_W   = 8;
  localparam int ATTR_W   = 8;
  localparam int IN_COL_W = 8;
  localparam int IN_ROW_W = 7;
  localparam int COL_W    = 7;
  localparam int ROW_W    = 5;
  localparam int OFS_W    = 11;
  localparam int CELL_W   = ATTR_W + CHAR_W;
  localparam int LIN_W    = 16;

  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;
  localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;

  localparam logic [COL_W-1:0]  COL_LAST     = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]  ROW_LAST     = ROW_W'(ROWS - 1);
  localparam logic [ADDR_W-1:0] CELL_LAST    = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] SCROLL_LAST  = ADDR_W'(CELLS - COLUMNS - 1);
  localparam logic [ADDR_W-1:0] BOTTOM_FIRST = ADDR_W'((ROWS - 1) * COLUMNS);
  localparam logic [ADDR_W-1:0] ROW_STRIDE   = ADDR_W'(COLUMNS);

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 3'd0,
    CMD_BS    = 3'd1,
    CMD_SET   = 3'd2,
    CMD_CLEAR = 3'd3,
    CMD_READ  = 3'd4
  } cmd_t;

  // Result handed from the sequencer to the output register
  typedef struct packed {
    logic              valid;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [OFS_W-1:0]  cursor_offset;
    logic [CELL_W-1:0] cell_data;
    logic              scrolled;
  } res_t;

  function automatic logic [LIN_W-1:0] lin_index(logic [ROW_W-1:0] row,
                                                 logic [COL_W-1:0] col);
    return LIN_W'(LIN_W'(row) * LIN_W'(COLUMNS) + LIN_W'(col));
  endfunction

  function automatic logic [COL_W-1:0] clamp_col(logic [IN_COL_W-1:0] c);
    if (c > IN_COL_W'(COLUMNS - 1)) begin
      return COL_LAST;
    end
    return c[COL_W-1:0];
  endfunction

  function automatic logic [ROW_W-1:0] clamp_row(logic [IN_ROW_W-1:0] r);
    if (r > IN_ROW_W'(ROWS - 1)) begin
      return ROW_LAST;
    end
    return r[ROW_W-1:0];
  endfunction

endpackage

@@ sv/tcc_in_if.sv @@
interface tcc_in_if;
  logic                           valid;
  logic                           ready;
  logic [tcc_pkg::CMD_W-1:0]      cmd;
  logic [tcc_pkg::CHAR_W-1:0]     char_code;
  logic [tcc_pkg::IN_COL_W-1:0]   col;
  logic [tcc_pkg::IN_ROW_W-1:0]   row;

  modport source (output valid, cmd, char_code, col, row, input ready);
  modport sink   (input valid, cmd, char_code, col, row, output ready);
endinterface

@@ sv/tcc_out_if.sv @@
interface tcc_out_if;
  logic                         valid;
  logic                         ready;
  logic [tcc_pkg::COL_W-1:0]    cursor_col;
  logic [tcc_pkg::ROW_W-1:0]    cursor_row;
  logic [tcc_pkg::OFS_W-1:0]    cursor_offset;
  logic [tcc_pkg::CELL_W-1:0]   cell_data;
  logic                         scrolled;

  modport source (output valid, cursor_col, cursor_row, cursor_offset, cell_data, scrolled,
                  input ready);
  modport sink   (input valid, cursor_col, cursor_row, cursor_offset, cell_data, scrolled,
                  output ready);
endinterface

@@ sv/tcc_cfg_if.sv @@
interface tcc_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [tcc_pkg::ATTR_W-1:0]   text_attribute;

  modport source (output valid, text_attribute, input ready);
  modport sink   (input valid, text_attribute, output ready);
endinterface

@@ sv/text_console_cursor_engine_unit.sv @@
// Channel  Dir  Handshake     Payload
// in_if    in   valid/ready   cmd, char_code, col, row
// out_if   out  valid/ready   cursor_col, cursor_row, cursor_offset, cell_data, scrolled
// cfg_if   in   valid/ready   text_attribute
//
// Put char, backspace, set cursor, read cell and unused commands: S_IDLE accepts the
// command and may touch the cell memory port, then S_EMIT hands the result on.
// Clear walks the whole cell memory, one cell a cycle.
// A scroll copies through the single read port and then blanks the bottom row;
// in_if stays stalled meanwhile.
// After reset a clearing pass over all ROWS*COLUMNS cells keeps in_if.ready low;
// cfg_if is always ready. A result waiting on out_if does not block the next command.
module text_console_cursor_engine_unit (
  input  logic     clk,
  input  logic     rst_n,
  tcc_in_if.sink   in_if,
  tcc_out_if.source out_if,
  tcc_cfg_if.sink  cfg_if
);

  logic [tcc_pkg::ATTR_W-1:0]  attr_r;
  tcc_pkg::res_t               res;
  logic                        res_take;

  logic                        out_valid_r;
  logic [tcc_pkg::COL_W-1:0]   out_col_r;
  logic [tcc_pkg::ROW_W-1:0]   out_row_r;
  logic [tcc_pkg::OFS_W-1:0]   out_ofs_r;
  logic [tcc_pkg::CELL_W-1:0]  out_data_r;
  logic                        out_scr_r;

  // attribute register; the user writes only while the engine is idle; not enforced here
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= tcc_pkg::ATTR_RESET;
    end else if (cfg_if.valid) begin
      attr_r <= cfg_if.text_attribute;
    end
  end

  // command sequencer with the cell memory
  tcc_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .attr     (attr_r),
    .res_take (res_take),
    .res      (res)
  );

  // output register: take a new result when empty or being drained
  assign res_take = !out_valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid && res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload: hold while the transaction is stalled
  always_ff @(posedge clk) begin
    if (res.valid && res_take) begin
      out_col_r  <= res.cursor_col;
      out_row_r  <= res.cursor_row;
      out_ofs_r  <= res.cursor_offset;
      out_data_r <= res.cell_data;
      out_scr_r  <= res.scrolled;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.cursor_col    = out_col_r;
  assign out_if.cursor_row    = out_row_r;
  assign out_if.cursor_offset = out_ofs_r;
  assign out_if.cell_data     = out_data_r;
  assign out_if.scrolled      = out_scr_r;

endmodule

@@ sv/tcc_ram.sv @@
module tcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/tcc_seq.sv @@
module tcc_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  tcc_in_if.sink                     in_if,
  input  logic [tcc_pkg::ATTR_W-1:0] attr,
  input  logic                       res_take,
  output tcc_pkg::res_t              res
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCROLL,
    S_BLANK,
    S_EMIT
  } state_t;

  state_t                         state_r;
  logic [tcc_pkg::ADDR_W-1:0]     cnt_r;
  logic                           init_r;
  logic                           wr_pend_r;
  logic [tcc_pkg::ADDR_W-1:0]     wr_addr_r;
  logic [tcc_pkg::COL_W-1:0]      col_r;
  logic [tcc_pkg::ROW_W-1:0]      row_r;
  logic                           read_r;
  logic                           scr_r;

  logic                           in_fire;
  tcc_pkg::cmd_t                  cmd;
  logic [tcc_pkg::COL_W-1:0]      bs_col;
  logic [tcc_pkg::ROW_W-1:0]      bs_row;
  logic [tcc_pkg::ATTR_W-1:0]     blank_attr;
  logic [tcc_pkg::LIN_W-1:0]      cur_lin;

  logic                           wr_en;
  logic [tcc_pkg::ADDR_W-1:0]     wr_addr;
  logic [tcc_pkg::CELL_W-1:0]     wr_data;
  logic                           rd_en;
  logic [tcc_pkg::ADDR_W-1:0]     rd_addr;
  logic [tcc_pkg::CELL_W-1:0]     rd_data;

  assign in_if.ready = (state_r == S_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign cmd         = tcc_pkg::cmd_t'(in_if.cmd);
  assign blank_attr  = init_r ? tcc_pkg::ATTR_RESET : attr;
  assign cur_lin     = tcc_pkg::lin_index(row_r, col_r);

  // step back, wrapping to the end of the previous row; home stays home
  always_comb begin
    bs_col = col_r;
    bs_row = row_r;
    if (col_r != '0) begin
      bs_col = col_r - 1'b1;
    end else if (row_r != '0) begin
      bs_col = tcc_pkg::COL_LAST;
      bs_row = row_r - 1'b1;
    end
  end

  // memory port control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_r;
    wr_data = {blank_attr, tcc_pkg::SPACE_CHAR};
    rd_en   = 1'b0;
    rd_addr = cnt_r + tcc_pkg::ROW_STRIDE;
    if (wr_pend_r) begin
      wr_en   = 1'b1;
      wr_addr = wr_addr_r;
      wr_data = rd_data;
    end else begin
      case (state_r)
        S_CLEAR, S_BLANK: begin
          wr_en = 1'b1;
        end
        S_IDLE: begin
          if (in_fire && cmd == tcc_pkg::CMD_PUT && in_if.char_code != tcc_pkg::NEWLINE_CHAR) begin
            wr_en   = 1'b1;
            wr_addr = cur_lin[tcc_pkg::ADDR_W-1:0];
            wr_data = {attr, in_if.char_code};
          end else if (in_fire && cmd == tcc_pkg::CMD_BS) begin
            wr_en   = 1'b1;
            wr_addr = tcc_pkg::ADDR_W'(tcc_pkg::lin_index(bs_row, bs_col));
          end
        end
        default: begin
        end
      endcase
    end
    if (state_r == S_SCROLL) begin
      rd_en = 1'b1;
    end else if (state_r == S_IDLE && in_fire && cmd == tcc_pkg::CMD_READ) begin
      rd_en   = 1'b1;
      rd_addr = tcc_pkg::ADDR_W'(tcc_pkg::lin_index(tcc_pkg::clamp_row(in_if.row),
                                                    tcc_pkg::clamp_col(in_if.col)));
    end
  end

  tcc_ram #(
    .WIDTH (tcc_pkg::CELL_W),
    .DEPTH (tcc_pkg::CELLS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      cnt_r     <= '0;
      init_r    <= 1'b1;
      wr_pend_r <= 1'b0;
      col_r     <= '0;
      row_r     <= '0;
      read_r    <= 1'b0;
      scr_r     <= 1'b0;
    end else begin
      case (state_r)
        S_CLEAR: begin
          if (cnt_r == tcc_pkg::CELL_LAST) begin
            cnt_r   <= '0;
            init_r  <= 1'b0;
            state_r <= init_r ? S_IDLE : S_EMIT;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            read_r  <= 1'b0;
            scr_r   <= 1'b0;
            state_r <= S_EMIT;
            case (cmd)
              tcc_pkg::CMD_PUT: begin
                if (in_if.char_code == tcc_pkg::NEWLINE_CHAR || col_r == tcc_pkg::COL_LAST) begin
                  col_r <= '0;
                  if (row_r == tcc_pkg::ROW_LAST) begin
                    scr_r   <= 1'b1;
                    cnt_r   <= '0;
                    state_r <= S_SCROLL;
                  end else begin
                    row_r <= row_r + 1'b1;
                  end
                end else begin
                  col_r <= col_r + 1'b1;
                end
              end
              tcc_pkg::CMD_BS: begin
                col_r <= bs_col;
                row_r <= bs_row;
              end
              tcc_pkg::CMD_SET: begin
                col_r <= tcc_pkg::clamp_col(in_if.col);
                row_r <= tcc_pkg::clamp_row(in_if.row);
              end
              tcc_pkg::CMD_CLEAR: begin
                col_r   <= '0;
                row_r   <= '0;
                cnt_r   <= '0;
                state_r <= S_CLEAR;
              end
              tcc_pkg::CMD_READ: begin
                read_r <= 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
        S_SCROLL: begin
          // read one row below, write it back in the next cycle
          wr_pend_r <= 1'b1;
          wr_addr_r <= cnt_r;
          if (cnt_r == tcc_pkg::SCROLL_LAST) begin
            cnt_r   <= tcc_pkg::BOTTOM_FIRST;
            state_r <= S_BLANK;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_BLANK: begin
          wr_pend_r <= 1'b0;
          if (!wr_pend_r) begin
            if (cnt_r == tcc_pkg::CELL_LAST) begin
              cnt_r   <= '0;
              state_r <= S_EMIT;
            end else begin
              cnt_r <= cnt_r + 1'b1;
            end
          end
        end
        S_EMIT: begin
          if (res_take) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign res.valid         = (state_r == S_EMIT);
  assign res.cursor_col    = col_r;
  assign res.cursor_row    = row_r;
  assign res.cursor_offset = cur_lin[tcc_pkg::OFS_W-1:0];
  assign res.cell_data     = read_r ? rd_data : '0;
  assign res.scrolled      = scr_r;

  a_no_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("read and write hit the same cell in one cycle");

  a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    (row_r <= tcc_pkg::ROW_LAST) && (col_r <= tcc_pkg::COL_LAST))
    else $error("cursor left the screen");

  a_pend_in_scroll: assert property (@(posedge clk) disable iff (!rst_n)
    wr_pend_r |-> (state_r == S_SCROLL || state_r == S_BLANK))
    else $error("copy write pending outside a scroll");

  a_read_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_if.cmd == tcc_pkg::CMD_READ) |=> (state_r == S_EMIT && read_r))
    else $error("cell read did not reach the result stage");

endmodule

@@ verif/text_console_cursor_engine_unit_tb.sv @@
module text_console_cursor_engine_unit_tb;
  import tcc_pkg::*;

  // Run guards. The limit is far above the slowest legal run: every command
  // a full scroll or clear, plus the longest sender gap and receiver stall.
  localparam int CYCLE_LIMIT   = 10_000_000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 20;

  // Opcodes above CMD_READ are unused; the block must answer them unchanged.
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = CMD_W'(CMD_READ + 1);
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = '1;

  typedef struct packed {
    logic [CMD_W-1:0]    opcode;
    logic [CHAR_W-1:0]   char_code;
    logic [IN_COL_W-1:0] col;
    logic [IN_ROW_W-1:0] row;
  } console_cmd_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [OFS_W-1:0]  cursor_offset;
    logic [CELL_W-1:0] cell_data;
    logic              scrolled;
  } cursor_report_t;

  logic clk = 1'b0;
  logic rst_n;

  always #5 clk = ~clk;

  tcc_in_if  in_if();
  tcc_out_if out_if();
  tcc_cfg_if cfg_if();

  text_console_cursor_engine_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  // Commands waiting to be driven, and cursor reports owed by the block.
  console_cmd_t   pending_cmds[$];
  cursor_report_t reports_due[$];

  // Shadow of the screen, cursor and attribute register.
  logic [CELL_W-1:0] screen_shadow [CELLS];
  logic [ATTR_W-1:0] attr_shadow;
  int                cur_col;
  int                cur_row;

  int   mismatches = 0;
  int   cycles = 0;
  bit   calm;         // when set, neither side idles
  int   hold_order;   // bumped to request one long receiver hold-off
  int   hold_done;
  int   hold_left;
  int   stall_left;
  int   send_gap;
  logic in_taken;     // a command transaction completed at the last rising edge
  logic cfg_taken;    // a register write completed at the last rising edge

  // ---------------------------------------------------------------------------
  // Screen shadow
  // ---------------------------------------------------------------------------
  function automatic logic [CELL_W-1:0] cell_of(logic [CHAR_W-1:0] ch);
    return {attr_shadow, ch};
  endfunction

  function automatic void blank_screen();
    for (int i = 0; i < CELLS; i++) screen_shadow[i] = cell_of(SPACE_CHAR);
  endfunction

  // Move every row up by one, blank the bottom row, pull the cursor up.
  function automatic void scroll_screen();
    for (int i = 0; i < CELLS - COLUMNS; i++) screen_shadow[i] = screen_shadow[i + COLUMNS];
    for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_shadow[i] = cell_of(SPACE_CHAR);
    if (cur_row > 0) cur_row--;
  endfunction

  function automatic int clamp_to(int v, int lim);
    return (v > lim - 1) ? lim - 1 : v;
  endfunction

  // Apply one command to the shadow and return the report the block owes.
  function automatic cursor_report_t apply_command(console_cmd_t c);
    cursor_report_t rpt;
    int             data;
    bit             rolled;
    data   = 0;
    rolled = 1'b0;
    case (c.opcode)
      CMD_PUT: begin
        if (c.char_code == NEWLINE_CHAR) begin
          cur_col = 0;
          cur_row++;
        end else begin
          screen_shadow[cur_row * COLUMNS + cur_col] = cell_of(c.char_code);
          if (cur_col + 1 < COLUMNS) begin
            cur_col++;
          end else begin
            cur_col = 0;
            cur_row++;
          end
        end
        if (cur_row >= ROWS) begin
          scroll_screen();
          rolled = 1'b1;
        end
      end
      CMD_BS: begin
        // Step back, wrapping to the end of the previous row; home stays home.
        if (cur_col > 0) begin
          cur_col--;
        end else if (cur_row > 0) begin
          cur_col = COLUMNS - 1;
          cur_row--;
        end
        screen_shadow[cur_row * COLUMNS + cur_col] = cell_of(SPACE_CHAR);
      end
      CMD_SET: begin
        cur_col = clamp_to(c.col, COLUMNS);
        cur_row = clamp_to(c.row, ROWS);
      end
      CMD_CLEAR: begin
        blank_screen();
        cur_col = 0;
        cur_row = 0;
      end
      CMD_READ: begin
        data = screen_shadow[clamp_to(c.row, ROWS) * COLUMNS + clamp_to(c.col, COLUMNS)];
      end
      default: ;
    endcase
    rpt.cursor_col    = COL_W'(cur_col);
    rpt.cursor_row    = ROW_W'(cur_row);
    rpt.cursor_offset = OFS_W'(cur_row * COLUMNS + cur_col);
    rpt.cell_data     = CELL_W'(data);
    rpt.scrolled      = rolled;
    return rpt;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_cmd(logic [CMD_W-1:0] op, int ch, int c, int r);
    console_cmd_t cmd;
    cmd.opcode    = op;
    cmd.char_code = CHAR_W'(ch);
    cmd.col       = IN_COL_W'(c);
    cmd.row       = IN_ROW_W'(r);
    pending_cmds.push_back(cmd);
  endfunction

  // Mostly on-screen coordinates; the rest exercise clamping and the top bits.
  function automatic int pick_col();
    return ($urandom_range(0, 9) < 7) ? $urandom_range(0, COLUMNS - 1)
                                      : $urandom_range(0, (1 << IN_COL_W) - 1);
  endfunction

  function automatic int pick_row();
    return ($urandom_range(0, 9) < 7) ? $urandom_range(0, ROWS - 1)
                                      : $urandom_range(0, (1 << IN_ROW_W) - 1);
  endfunction

  function automatic int pick_char();
    return ($urandom_range(0, 9) == 0) ? int'(NEWLINE_CHAR) : $urandom_range(0, 255);
  endfunction

  // Idle length for either side: mostly none, some short, a few long.
  function automatic int idle_length();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  function automatic void queue_random(int count);
    int added;
    int kind;
    int c0;
    int r0;
    int k;
    int roll;
    logic [CMD_W-1:0] op;
    added = 0;
    while (added < count) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        // Place the cursor, type a few characters, read them back.
        c0 = $urandom_range(0, COLUMNS - 1);
        r0 = $urandom_range(0, ROWS - 1);
        k  = $urandom_range(1, 6);
        queue_cmd(CMD_SET, $urandom_range(0, 255), c0, r0);
        for (int i = 0; i < k; i++) queue_cmd(CMD_PUT, pick_char(), pick_col(), pick_row());
        for (int i = 0; i < k; i++) queue_cmd(CMD_READ, $urandom_range(0, 255), c0 + i, r0);
        added += 2 * k + 1;
        if ($urandom_range(0, 1) == 1) begin
          queue_cmd(CMD_BS, $urandom_range(0, 255), pick_col(), pick_row());
          added++;
        end
      end else if (kind < 52) begin
        // Drive the cursor onto the bottom row and type there; a newline or wrap scrolls.
        queue_cmd(CMD_SET, $urandom_range(0, 255), pick_col(),
                  $urandom_range(ROWS - 1, (1 << IN_ROW_W) - 1));
        k = $urandom_range(1, 4);
        for (int i = 0; i < k; i++)
          queue_cmd(CMD_PUT, ($urandom_range(0, 1) == 1) ? int'(NEWLINE_CHAR)
                                                          : $urandom_range(0, 255),
                    pick_col(), pick_row());
        queue_cmd(CMD_READ, $urandom_range(0, 255), $urandom_range(0, COLUMNS - 1), ROWS - 2);
        added += k + 2;
      end else begin
        // Lone command with every field random.
        roll = $urandom_range(0, 99);
        if (roll < 40)      op = CMD_PUT;
        else if (roll < 55) op = CMD_BS;
        else if (roll < 70) op = CMD_SET;
        else if (roll < 88) op = CMD_READ;
        else if (roll < 94) op = CMD_CLEAR;
        else                op = CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
        queue_cmd(op, (op == CMD_PUT) ? pick_char() : $urandom_range(0, 255),
                  pick_col(), pick_row());
        added++;
      end
    end
  endfunction

  // Sender pause: hold off until the queue is drained and every report is in.
  // The first loop polls at rising edges, where the driven inputs are stable;
  // the second at falling edges, where the report queue is stable.
  task automatic wait_idle();
    while (pending_cmds.size() != 0 || in_if.valid) @(posedge clk);
    while (reports_due.size() != 0) @(negedge clk);
  endtask

  // Write the attribute register; the block must be idle.
  task automatic write_attribute(logic [ATTR_W-1:0] value);
    @(negedge clk);
    cfg_if.valid          <= 1'b1;
    cfg_if.text_attribute <= value;
    do @(negedge clk); while (!cfg_taken);
    cfg_if.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Command driver: launch at the falling edge, hold until taken, then either
  // advance to the next pending command or drop valid for a gap.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : cmd_driver
    console_cmd_t next_cmd;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      send_gap    <= 0;
    end else if (!in_if.valid || in_taken) begin
      if (send_gap > 0) begin
        send_gap    <= send_gap - 1;
        in_if.valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        next_cmd        = pending_cmds.pop_front();
        in_if.cmd       <= next_cmd.opcode;
        in_if.char_code <= next_cmd.char_code;
        in_if.col       <= next_cmd.col;
        in_if.row       <= next_cmd.row;
        in_if.valid     <= 1'b1;
        send_gap        <= idle_length();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: random stalls, plus a long hold-off on request so the
  // block fills up and stalls its command input.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : report_sink
    int gap;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_left    <= 0;
      stall_left   <= 0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else if (hold_done != hold_order) begin
      hold_done    <= hold_order;
      hold_left    <= HOLD_CYCLES - 1;
      out_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      gap          = idle_length();
      out_if.ready <= (gap == 0);
      stall_left   <= (gap > 0) ? gap - 1 : 0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: at each rising edge check any completed result transaction first,
  // then fold a completed command or register write into the shadow.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    cursor_report_t want;
    console_cmd_t   seen;
    in_taken  <= rst_n && in_if.valid && in_if.ready;
    cfg_taken <= rst_n && cfg_if.valid && cfg_if.ready;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (reports_due.size() == 0) begin
          $error("result with no command outstanding: col %0d row %0d",
                 out_if.cursor_col, out_if.cursor_row);
          mismatches++;
        end else begin
          want = reports_due.pop_front();
          if (out_if.cursor_col !== want.cursor_col) begin
            $error("cursor_col: expected %0d, got %0d", want.cursor_col, out_if.cursor_col);
            mismatches++;
          end
          if (out_if.cursor_row !== want.cursor_row) begin
            $error("cursor_row: expected %0d, got %0d", want.cursor_row, out_if.cursor_row);
            mismatches++;
          end
          if (out_if.cursor_offset !== want.cursor_offset) begin
            $error("cursor_offset: expected %0d, got %0d",
                   want.cursor_offset, out_if.cursor_offset);
            mismatches++;
          end
          if (out_if.cell_data !== want.cell_data) begin
            $error("cell_data: expected %h, got %h", want.cell_data, out_if.cell_data);
            mismatches++;
          end
          if (out_if.scrolled !== want.scrolled) begin
            $error("scrolled: expected %0d, got %0d", want.scrolled, out_if.scrolled);
            mismatches++;
          end
        end
      end
      if (cfg_if.valid && cfg_if.ready) attr_shadow = cfg_if.text_attribute;
      if (in_if.valid && in_if.ready) begin
        seen.opcode    = in_if.cmd;
        seen.char_code = in_if.char_code;
        seen.col       = in_if.col;
        seen.row       = in_if.row;
        reports_due.push_back(apply_command(seen));
      end
    end
  end

  // Watchdog: covers a hung handshake anywhere in the run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  initial begin
    rst_n                 = 1'b0;
    in_if.valid           = 1'b0;
    in_if.cmd             = CMD_PUT;
    in_if.char_code       = '0;
    in_if.col             = '0;
    in_if.row             = '0;
    out_if.ready          = 1'b0;
    cfg_if.valid          = 1'b0;
    cfg_if.text_attribute = ATTR_RESET;
    calm                  = 1'b0;
    hold_order            = 0;
    hold_done             = 0;
    hold_left             = 0;
    stall_left            = 0;
    send_gap              = 0;
    in_taken              = 1'b0;
    cfg_taken             = 1'b0;
    attr_shadow           = ATTR_RESET;
    blank_screen();
    cur_col = 0;
    cur_row = 0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed pass at the reset attribute.
    queue_cmd(CMD_READ, 0, 0, 0);                   // blank cell after reset
    queue_cmd(CMD_BS, 0, 0, 0);                     // backspace at home
    queue_cmd(CMD_PUT, 8'h41, 0, 0);
    queue_cmd(CMD_PUT, 8'h00, 0, 0);                // zero byte is a real character
    queue_cmd(CMD_PUT, 8'hFF, 0, 0);
    queue_cmd(CMD_READ, 0, 1, 0);
    queue_cmd(CMD_READ, 0, 2, 0);
    queue_cmd(CMD_BS, 0, 0, 0);
    queue_cmd(CMD_SET, 0, 5, 3);
    queue_cmd(CMD_PUT, NEWLINE_CHAR, 0, 0);         // newline mid-screen
    queue_cmd(CMD_BS, 0, 0, 0);                     // wrap back to previous row end
    queue_cmd(CMD_SET, 0, COLUMNS - 1, 0);
    queue_cmd(CMD_PUT, 8'h78, 0, 0);                // wrap at end of row, no scroll
    queue_cmd(CMD_SET, 8'hFF, 8'hFF, 7'h7F);        // clamp to bottom-right
    queue_cmd(CMD_PUT, 8'h5A, 0, 0);                // wrap off the last row: scroll
    queue_cmd(CMD_READ, 0, COLUMNS - 1, ROWS - 2);
    queue_cmd(CMD_SET, 0, 10, ROWS - 1);
    queue_cmd(CMD_PUT, NEWLINE_CHAR, 0, 0);         // newline on the last row: scroll
    queue_cmd(CMD_READ, 0, 200, 100);               // clamped read
    queue_cmd(CMD_SPARE_FIRST, 8'hFF, 8'hFF, 7'h7F);
    queue_cmd(CMD_W'(CMD_SPARE_FIRST + 1), 8'hFF, 8'hFF, 7'h7F);
    queue_cmd(CMD_SPARE_LAST, 8'hFF, 8'hFF, 7'h7F);
    queue_cmd(CMD_CLEAR, 0, 0, 0);
    queue_cmd(CMD_READ, 0, 0, 0);
    wait_idle();

    // Random phases, each at its own attribute; extremes first.
    write_attribute(8'h00);
    queue_random(200);
    wait_idle();

    write_attribute(8'hFF);
    queue_random(200);
    hold_order++;                                   // long receiver hold-off
    wait_idle();

    write_attribute(ATTR_W'($urandom_range(0, 255)));
    calm = 1'b1;                                    // back-to-back, no idling
    queue_random(200);
    wait_idle();
    calm = 1'b0;

    write_attribute(ATTR_W'($urandom_range(0, 255)));
    queue_random(300);
    hold_order++;
    wait_idle();

    write_attribute(ATTR_RESET);
    queue_random(200);
    wait_idle();

    write_attribute(8'h80);
    queue_random(200);
    wait_idle();

    // Let any stray result surface before the verdict.
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && reports_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/tcc_pkg.sv
sv/tcc_in_if.sv
sv/tcc_out_if.sv
sv/tcc_cfg_if.sv
sv/tcc_ram.sv
sv/tcc_seq.sv
sv/text_console_cursor_engine_unit.sv
verif/text_console_cursor_engine_unit_tb.sv
